// File: design/b2r_pkg.sv
// Package for the BMP 24-bit to RGB565 stream converter.
// Holds the payload structs, codes and sizing constants shared by all modules.
// Depends on nothing.
package b2r_pkg;

    // Largest image side in pixels that the converter accepts.
    localparam int MAX_DIM = 1024;
    // Bits for a pixel count up to MAX_DIM, and for a column index below it.
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int COL_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam int WIN_W = 11;
    localparam int BUF_W = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int PIXEL_INDEX_W = 20;

    // Padded row bytes are at most 3 * MAX_DIM + 3.
    localparam int ROW_BYTES_W = DIM_W + 2;
    localparam int NEED_PROD_W = ROW_BYTES_W + DIM_W;
    localparam int NEED_W = 33;
    localparam int IDX_SUM_W = (2 * DIM_W + 1 > PIXEL_INDEX_W) ? 2 * DIM_W + 1 : PIXEL_INDEX_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Header layout, byte positions in the file.
    localparam logic [5:0] POS_OFFSET_LO = 6'd10;
    localparam logic [5:0] POS_OFFSET_HI = 6'd13;
    localparam logic [5:0] POS_WIDTH_LO = 6'd18;
    localparam logic [5:0] POS_WIDTH_HI = 6'd21;
    localparam logic [5:0] POS_HEIGHT_LO = 6'd22;
    localparam logic [5:0] POS_HEIGHT_HI = 6'd25;
    localparam logic [5:0] POS_DEPTH_LO = 6'd28;
    localparam logic [5:0] POS_DEPTH_HI = 6'd29;
    localparam logic [5:0] POS_COMP_LO = 6'd30;
    localparam logic [5:0] POS_COMP_HI = 6'd33;
    localparam logic [31:0] HEADER_END = 32'd33;
    localparam logic [31:0] MIN_OFFSET = 32'd34;
    localparam logic [15:0] DEPTH_24 = 16'd24;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(320);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_WIDTH = 2'd0,
        CFG_WINDOW_HEIGHT = 2'd1,
        CFG_BUFFER_SIZE = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        RK_PIXEL = 3'd0,
        RK_BAD_FORMAT = 3'd1,
        RK_SIZE_MISMATCH = 3'd2,
        RK_BUFFER_SHORT = 3'd3,
        RK_BAD_OFFSET = 3'd4
    } result_kind_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP = 2'd1,
        PH_PIXELS = 2'd2,
        PH_IGNORE = 2'd3
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               result_kind;
        logic [15:0]              pixel_value;
        logic [PIXEL_INDEX_W-1:0] pixel_index;
        logic                     last_pixel;
    } out_item_t;

    // Work handed from the parser to the output stage.
    typedef struct packed {
        result_kind_t     kind;
        logic [15:0]      pixel;
        logic [DIM_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [DIM_W-1:0] width;
        logic             last;
    } job_t;

endpackage

// File: design/b2r_front.sv
// Parser front end: takes file bytes, collects and checks the header,
// tracks pixel position and emits one job per pixel or error. Uses b2r_pkg.
module b2r_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [b2r_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [b2r_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               take,
    input  b2r_pkg::in_item_t                  item,
    output logic                               push,
    output b2r_pkg::job_t                      job
);

    localparam int DW = b2r_pkg::DIM_W;
    localparam int CW = b2r_pkg::COL_W;

    // Configuration registers
    logic [b2r_pkg::WIN_W-1:0] win_width_reg;
    logic [b2r_pkg::WIN_W-1:0] win_height_reg;
    logic [b2r_pkg::BUF_W-1:0] buf_size_reg;

    // Parse state
    b2r_pkg::parse_phase_t phase_reg, phase_next;
    logic [31:0]   pos_reg, pos_next;
    logic [31:0]   offset_reg, offset_next;
    logic [31:0]   img_width_reg, img_width_next;
    logic [31:0]   img_height_reg, img_height_next;
    logic [15:0]   depth_reg, depth_next;
    logic [31:0]   comp_reg, comp_next;
    logic [7:0]    blue_reg, blue_next;
    logic [7:0]    green_reg, green_next;
    logic [1:0]    trip_reg, trip_next;
    logic [CW-1:0] col_reg, col_next;
    logic [DW-1:0] rows_reg, rows_next;
    logic [1:0]    pad_reg, pad_next;

    // Size product for the buffer check, built while the header streams in.
    logic [b2r_pkg::ROW_BYTES_W-1:0] row_bytes_reg;
    logic [b2r_pkg::NEED_PROD_W-1:0] need_prod_reg;

    logic [7:0]    b;
    logic [5:0]    hdr_pos;
    logic [1:0]    byte_sel;
    logic          hdr_end;
    logic          comp_nz;
    logic          bad_format;
    logic          bad_size;
    logic [b2r_pkg::NEED_W-1:0] need;
    logic          buf_short;
    logic          bad_offset;
    b2r_pkg::result_kind_t err_kind;
    logic          hdr_err;
    logic [DW-1:0] w;
    logic [DW-1:0] col_inc;
    logic          row_done;
    logic          fin;
    logic          emit;
    logic [1:0]    row_pad;
    logic [1:0]    w3_low;
    logic          skip_done;

    assign b = item.byte_value;
    assign hdr_pos = pos_reg[5:0];
    // Byte lane within a four-byte field; every such field starts at a position of 2 mod 4.
    assign byte_sel = 2'(hdr_pos[1:0] - 2'd2);
    assign hdr_end = (phase_reg == b2r_pkg::PH_HEADER) && (pos_reg == b2r_pkg::HEADER_END);

    // The last compression byte arrives with the check itself.
    assign comp_nz = (comp_reg != 32'd0) || (b != 8'd0);
    assign bad_format = (depth_reg != b2r_pkg::DEPTH_24) || comp_nz;
    assign bad_size = (img_width_reg != 32'(win_width_reg))
        || (img_height_reg != 32'(win_height_reg))
        || (img_width_reg == 32'd0) || (img_height_reg == 32'd0)
        || (img_width_reg > 32'(b2r_pkg::MAX_DIM))
        || (img_height_reg > 32'(b2r_pkg::MAX_DIM));
    assign need = b2r_pkg::NEED_W'(need_prod_reg) + b2r_pkg::NEED_W'(offset_reg);
    assign buf_short = b2r_pkg::NEED_W'(buf_size_reg) < need;
    assign bad_offset = offset_reg < b2r_pkg::MIN_OFFSET;
    assign hdr_err = bad_format || bad_size || buf_short || bad_offset;

    always_comb
    begin
        if (bad_format)
            err_kind = b2r_pkg::RK_BAD_FORMAT;
        else if (bad_size)
            err_kind = b2r_pkg::RK_SIZE_MISMATCH;
        else if (buf_short)
            err_kind = b2r_pkg::RK_BUFFER_SHORT;
        else if (bad_offset)
            err_kind = b2r_pkg::RK_BAD_OFFSET;
        else
            err_kind = b2r_pkg::RK_PIXEL;
    end

    assign w = img_width_reg[DW-1:0];
    assign w3_low = 2'(w[1:0] * 2'd3);
    assign row_pad = 2'(2'd0 - w3_low);
    assign col_inc = DW'(col_reg) + DW'(1);
    assign row_done = col_inc >= w;
    assign fin = (rows_reg <= DW'(1)) && row_done;
    assign emit = (phase_reg == b2r_pkg::PH_PIXELS) && (pad_reg == 2'd0) && (trip_reg == 2'd2);
    assign skip_done = (pos_reg + 32'd1) == offset_reg;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                b2r_pkg::PH_HEADER:
                begin
                    if (hdr_end)
                    begin
                        if (hdr_err)
                            phase_next = b2r_pkg::PH_IGNORE;
                        else if (offset_reg == b2r_pkg::MIN_OFFSET)
                            phase_next = b2r_pkg::PH_PIXELS;
                        else
                            phase_next = b2r_pkg::PH_SKIP;
                    end
                end
                b2r_pkg::PH_SKIP:
                begin
                    if (skip_done)
                        phase_next = b2r_pkg::PH_PIXELS;
                end
                b2r_pkg::PH_PIXELS:
                begin
                    if (emit && fin)
                        phase_next = b2r_pkg::PH_IGNORE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (item.byte_last)
                phase_next = b2r_pkg::PH_HEADER;
        end
    end

    // Header fields and pixel position
    always_comb
    begin
        pos_next = pos_reg;
        offset_next = offset_reg;
        img_width_next = img_width_reg;
        img_height_next = img_height_reg;
        depth_next = depth_reg;
        comp_next = comp_reg;
        blue_next = blue_reg;
        green_next = green_reg;
        trip_next = trip_reg;
        col_next = col_reg;
        rows_next = rows_reg;
        pad_next = pad_reg;
        if (take)
        begin
            pos_next = pos_reg + 32'd1;
            if (phase_reg == b2r_pkg::PH_HEADER)
            begin
                // Header fields are little-endian; every byte lands once.
                case (hdr_pos) inside
                    [b2r_pkg::POS_OFFSET_LO:b2r_pkg::POS_OFFSET_HI]:
                        offset_next[8*byte_sel +: 8] = b;
                    [b2r_pkg::POS_WIDTH_LO:b2r_pkg::POS_WIDTH_HI]:
                        img_width_next[8*byte_sel +: 8] = b;
                    [b2r_pkg::POS_HEIGHT_LO:b2r_pkg::POS_HEIGHT_HI]:
                        img_height_next[8*byte_sel +: 8] = b;
                    [b2r_pkg::POS_DEPTH_LO:b2r_pkg::POS_DEPTH_HI]:
                        depth_next[8*hdr_pos[0] +: 8] = b;
                    [b2r_pkg::POS_COMP_LO:b2r_pkg::POS_COMP_HI]:
                        comp_next[8*byte_sel +: 8] = b;
                    default:
                    begin
                    end
                endcase
                if (hdr_end && !hdr_err)
                begin
                    rows_next = img_height_reg[DW-1:0];
                    col_next = '0;
                    trip_next = 2'd0;
                    pad_next = 2'd0;
                end
            end
            else if (phase_reg == b2r_pkg::PH_PIXELS)
            begin
                if (pad_reg != 2'd0)
                begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1)
                        rows_next = rows_reg - DW'(1);
                end
                else if (trip_reg == 2'd0)
                begin
                    blue_next = b;
                    trip_next = 2'd1;
                end
                else if (trip_reg == 2'd1)
                begin
                    green_next = b;
                    trip_next = 2'd2;
                end
                else
                begin
                    trip_next = 2'd0;
                    blue_next = 8'd0;
                    green_next = 8'd0;
                    col_next = col_inc[CW-1:0];
                    if (!fin && row_done)
                    begin
                        col_next = '0;
                        pad_next = row_pad;
                        if (row_pad == 2'd0)
                            rows_next = rows_reg - DW'(1);
                    end
                end
            end
            if (item.byte_last)
            begin
                pos_next = '0;
                offset_next = '0;
                img_width_next = '0;
                img_height_next = '0;
                depth_next = '0;
                comp_next = '0;
                blue_next = '0;
                green_next = '0;
                trip_next = '0;
                col_next = '0;
                rows_next = '0;
                pad_next = '0;
            end
        end
    end

    // Job output
    always_comb
    begin
        push = 1'b0;
        job = '0;
        if (take && hdr_end && hdr_err)
        begin
            push = 1'b1;
            job.kind = err_kind;
        end
        else if (take && emit)
        begin
            push = 1'b1;
            job.kind = b2r_pkg::RK_PIXEL;
            job.pixel = {b[7:3], green_reg[7:2], blue_reg[7:3]};
            job.row = (rows_reg != '0) ? rows_reg - DW'(1) : '0;
            job.col = col_reg;
            job.width = w;
            job.last = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_width_reg <= b2r_pkg::WIN_RESET;
            win_height_reg <= b2r_pkg::WIN_RESET;
            buf_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                b2r_pkg::CFG_WINDOW_WIDTH:
                    win_width_reg <= cfg_data[b2r_pkg::WIN_W-1:0];
                b2r_pkg::CFG_WINDOW_HEIGHT:
                    win_height_reg <= cfg_data[b2r_pkg::WIN_W-1:0];
                b2r_pkg::CFG_BUFFER_SIZE:
                    buf_size_reg <= cfg_data[b2r_pkg::BUF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b2r_pkg::PH_HEADER;
            pos_reg <= '0;
            offset_reg <= '0;
            img_width_reg <= '0;
            img_height_reg <= '0;
            depth_reg <= '0;
            comp_reg <= '0;
            blue_reg <= '0;
            green_reg <= '0;
            trip_reg <= '0;
            col_reg <= '0;
            rows_reg <= '0;
            pad_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            offset_reg <= offset_next;
            img_width_reg <= img_width_next;
            img_height_reg <= img_height_next;
            depth_reg <= depth_next;
            comp_reg <= comp_next;
            blue_reg <= blue_next;
            green_reg <= green_next;
            trip_reg <= trip_next;
            col_reg <= col_next;
            rows_reg <= rows_next;
            pad_reg <= pad_next;
        end
    end

    // Width is complete after byte 21 and height after byte 25, so the
    // product has settled well before the check at byte 33.
    always_ff @(posedge clk)
    begin
        row_bytes_reg <= b2r_pkg::ROW_BYTES_W'(w) * b2r_pkg::ROW_BYTES_W'(3)
            + b2r_pkg::ROW_BYTES_W'(row_pad);
        need_prod_reg <= b2r_pkg::NEED_PROD_W'(row_bytes_reg)
            * b2r_pkg::NEED_PROD_W'(img_height_reg[DW-1:0]);
    end

endmodule

// File: design/b2r_queue.sv
// Short job queue between the parser and the output stage.
// Uses b2r_pkg for the job type and depth.
module b2r_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  b2r_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output b2r_pkg::job_t head_job
);

    b2r_pkg::job_t slot_reg [b2r_pkg::QUEUE_DEPTH];
    logic [b2r_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [b2r_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [b2r_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full = count_reg == b2r_pkg::QCNT_W'(b2r_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == b2r_pkg::QPTR_W'(b2r_pkg::QUEUE_DEPTH - 1))
                ? '0 : wr_ptr_reg + b2r_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == b2r_pkg::QPTR_W'(b2r_pkg::QUEUE_DEPTH - 1))
                ? '0 : rd_ptr_reg + b2r_pkg::QPTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + b2r_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - b2r_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: design/b2r_back.sv
// Output stage: turns a queued job into a result transaction, computing the
// destination index with one multiply into the output register. Uses b2r_pkg.
module b2r_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  b2r_pkg::job_t      head_job,
    output logic               pop,
    output logic               dst_valid,
    input  logic               dst_ready,
    output b2r_pkg::out_item_t dst_item
);

    localparam int SW = b2r_pkg::IDX_SUM_W;

    logic               out_valid_reg, out_valid_next;
    b2r_pkg::out_item_t out_item_reg, out_item_next;
    logic [SW-1:0]      index_sum;

    assign pop = head_valid && (!out_valid_reg || dst_ready);
    assign index_sum = SW'(head_job.row) * SW'(head_job.width) + SW'(head_job.col);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (dst_ready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        out_item_next.result_kind = head_job.kind;
        out_item_next.pixel_value = head_job.pixel;
        out_item_next.pixel_index = index_sum[b2r_pkg::PIXEL_INDEX_W-1:0];
        out_item_next.last_pixel = head_job.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_item_reg <= out_item_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_item = out_item_reg;

endmodule

// File: design/bmp24_to_rgb565_stream_unit.sv
// Top level of the BMP 24-bit to RGB565 stream converter.
// Throughput: one file byte per cycle. The parser pushes the job for an accepted byte into a
// two-entry queue, and from there it is loaded into the output register before it is valid.
// Input stalls only when the two-entry job queue is full behind a stalled output.
// Reset (rst_n, asynchronous, active low) restores window size 320 x 320, buffer size 0,
// and puts the parser at the start of a file. Depends on b2r_pkg and its submodules.
module bmp24_to_rgb565_stream_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [b2r_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [b2r_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            src_valid,
    output logic                            src_ready,
    input  b2r_pkg::in_item_t               src_item,
    output logic                            dst_valid,
    input  logic                            dst_ready,
    output b2r_pkg::out_item_t              dst_item
);

    logic          take;
    logic          push;
    b2r_pkg::job_t push_job;
    logic          pop;
    logic          full;
    logic          head_valid;
    b2r_pkg::job_t head_job;

    assign src_ready = !full;
    assign take = src_valid && src_ready;

    b2r_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (src_item),
        .push      (push),
        .job       (push_job)
    );

    b2r_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b2r_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .dst_valid  (dst_valid),
        .dst_ready  (dst_ready),
        .dst_item   (dst_item)
    );

endmodule
